// File: rtl/cpdr_pkg.sv
// ----------------------------------------------------------------------------
// cpdr_pkg: shared types and constants
// Command word passed from the byte classifier to the count expander,
// plus code-field constants of the compressed profile format.
// ----------------------------------------------------------------------------
package cpdr_pkg;

    localparam int CODE_W  = 8;
    localparam int COUNT_W = 16;
    localparam int LEN_W   = 20;
    localparam int RUN_W   = 6;

    localparam logic [LEN_W-1:0]   LEN_MAX   = 20'hFFFFF;
    localparam logic [COUNT_W-1:0] VALUE_MAX = 16'hFFFF;

    localparam int QUEUE_DEPTH = 2;

    // Result kinds.
    localparam logic KIND_COUNT  = 1'b0;
    localparam logic KIND_LENGTH = 1'b1;

    // Unfinished two-byte code held by the classifier.
    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_ABS   = 2'd1,
        PEND_DELTA = 2'd2
    } pend_t;

    // One command: optionally restart the length tally, emit cnt copies of
    // value, then optionally report the length and close the profile.
    typedef struct packed {
        logic               clr;
        logic               fin;
        logic [RUN_W-1:0]   cnt;
        logic [COUNT_W-1:0] value;
    } cmd_t;

endpackage

// File: rtl/count_profile_delta_run_decoder.sv
// ----------------------------------------------------------------------------
// count_profile_delta_run_decoder: count profile byte-stream decoder
// A byte's words pass through the command queue and the expander's registers.
// Throughput: a byte is taken each cycle while the command queue has room; the
// expander emits one word per cycle while the output is free and below the
// limit, returning to idle between commands; a final byte adds the length word.
// Reset: asynchronous, active low; clears all profile state and the queue and
// sets the length limit to its maximum.
// ----------------------------------------------------------------------------
module count_profile_delta_run_decoder #(
    parameter int QUEUE_DEPTH = cpdr_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cpdr_pkg::LEN_W-1:0]    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cpdr_pkg::CODE_W-1:0]   code_byte,
    input  logic                          first_byte,
    input  logic                          final_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          kind,
    output logic [cpdr_pkg::COUNT_W-1:0]  value,
    output logic [cpdr_pkg::LEN_W-1:0]    position,
    output logic                          last
);
    import cpdr_pkg::*;

    logic [LEN_W-1:0] max_len_reg;
    logic             accept;
    logic             push;
    cmd_t             push_cmd;
    logic             q_full;
    logic             q_not_empty;
    cmd_t             q_head;
    logic             q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= LEN_MAX;
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_wdata;
        end
    end

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    cpdr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .code_byte  (code_byte),
        .first_byte (first_byte),
        .final_byte (final_byte),
        .push       (push),
        .cmd        (push_cmd)
    );

    cpdr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    cpdr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .max_len   (max_len_reg),
        .cmd_valid (q_not_empty),
        .cmd       (q_head),
        .cmd_pop   (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .value     (value),
        .position  (position),
        .last      (last)
    );

    // A length word always closes the words of its byte.
    a_len_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_LENGTH) |-> last)
        else $error("length word without last");

    // The length value is the position saturated to 16 bits.
    a_len_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_LENGTH) |->
            (value == ((position > LEN_W'(VALUE_MAX)) ? VALUE_MAX : position[COUNT_W-1:0])))
        else $error("length value does not match position");

    // Count words are only shown for positions below the limit.
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_COUNT) |-> (position < max_len_reg))
        else $error("count word at or beyond the limit");

endmodule

// File: rtl/cpdr_front.sv
// ----------------------------------------------------------------------------
// cpdr_front: byte classifier
// Tracks the current count and any unfinished two-byte code, and turns an
// accepted byte that yields counts or carries a start or end mark into a command.
// ----------------------------------------------------------------------------
module cpdr_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [cpdr_pkg::CODE_W-1:0]     code_byte,
    input  logic                            first_byte,
    input  logic                            final_byte,
    output logic                            push,
    output cpdr_pkg::cmd_t                  cmd
);
    import cpdr_pkg::*;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [CODE_W-1:0]  high_reg, high_next;
    pend_t              pend_reg, pend_next;
    logic [COUNT_W-1:0] new_count;
    logic [RUN_W-1:0]   new_cnt;
    logic [14:0]        long_sum;

    always_comb
    begin
        new_count = count_reg;
        new_cnt   = '0;
        high_next = high_reg;
        pend_next = pend_reg;
        long_sum  = count_reg[14:0] + {high_reg[6:0], code_byte};
        if (first_byte)
        begin
            if (code_byte[7])
            begin
                new_count = '0;
                pend_next = PEND_ABS;
                high_next = code_byte;
            end
            else
            begin
                new_count = {8'd0, code_byte};
                new_cnt   = RUN_W'(1);
                pend_next = PEND_NONE;
            end
        end
        else
        begin
            case (pend_reg)
                PEND_ABS:
                begin
                    new_count = {1'b0, high_reg[6:0], code_byte};
                    new_cnt   = RUN_W'(1);
                    pend_next = PEND_NONE;
                end
                PEND_DELTA:
                begin
                    new_count = {1'b0, long_sum};
                    new_cnt   = RUN_W'(1);
                    pend_next = PEND_NONE;
                end
                default:
                begin
                    pend_next = PEND_NONE;
                    if (code_byte[7:6] == 2'b00)
                    begin
                        new_cnt = code_byte[RUN_W-1:0];
                    end
                    else if (code_byte[7])
                    begin
                        pend_next = PEND_DELTA;
                        high_next = code_byte;
                    end
                    else
                    begin
                        // Short delta: sign-extend the 6-bit field.
                        new_count = count_reg + {{10{code_byte[5]}}, code_byte[5:0]};
                        new_cnt   = RUN_W'(1);
                    end
                end
            endcase
        end

        cmd.clr   = first_byte;
        cmd.fin   = final_byte;
        cmd.cnt   = new_cnt;
        cmd.value = new_count;
        push      = accept && (first_byte || final_byte || (new_cnt != '0));

        count_next = new_count;
        if (final_byte)
        begin
            // A code left unfinished by the final byte is dropped.
            count_next = '0;
            high_next  = '0;
            pend_next  = PEND_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            high_reg  <= '0;
            pend_reg  <= PEND_NONE;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            high_reg  <= high_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

// File: rtl/cpdr_fifo.sv
// ----------------------------------------------------------------------------
// cpdr_fifo: command queue
// Small first-in first-out queue of commands between classifier and expander.
// ----------------------------------------------------------------------------
module cpdr_fifo #(
    parameter int DEPTH = cpdr_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cpdr_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output cpdr_pkg::cmd_t head
);
    import cpdr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] fill_reg;

    assign full      = (fill_reg == CW'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/cpdr_back.sv
// ----------------------------------------------------------------------------
// cpdr_back: count expander
// Executes commands: keeps the length tally, emits one count word per cycle, while the
// output is free and below the limit, and reports the length at the end of a profile.
// ----------------------------------------------------------------------------
module cpdr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [cpdr_pkg::LEN_W-1:0]    max_len,
    input  logic                          cmd_valid,
    input  cpdr_pkg::cmd_t                cmd,
    output logic                          cmd_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          kind,
    output logic [cpdr_pkg::COUNT_W-1:0]  value,
    output logic [cpdr_pkg::LEN_W-1:0]    position,
    output logic                          last
);
    import cpdr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_LEN
    } state_t;

    state_t             state_reg, state_next;
    logic [RUN_W-1:0]   rem_reg, rem_next;
    logic [COUNT_W-1:0] val_reg, val_next;
    logic               fin_reg, fin_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               ov_reg, ov_next;
    logic               kind_reg, kind_next;
    logic [COUNT_W-1:0] value_reg, value_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic               last_reg, last_next;
    logic               slot_free;
    logic [LEN_W:0]     len_plus;

    assign slot_free = !ov_reg || out_ready;
    assign cmd_pop   = (state_reg == S_IDLE) && cmd_valid;
    assign len_plus  = {1'b0, len_reg} + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        val_next   = val_reg;
        fin_next   = fin_reg;
        len_next   = len_reg;
        ov_next    = ov_reg && !out_ready;
        kind_next  = kind_reg;
        value_next = value_reg;
        pos_next   = pos_reg;
        last_next  = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    rem_next = cmd.cnt;
                    val_next = cmd.value;
                    fin_next = cmd.fin;
                    if (cmd.clr)
                    begin
                        len_next = '0;
                    end
                    if (cmd.cnt != '0)
                    begin
                        state_next = S_RUN;
                    end
                    else if (cmd.fin)
                    begin
                        state_next = S_LEN;
                    end
                end
            end
            S_RUN:
            begin
                if (slot_free)
                begin
                    if (len_reg < max_len)
                    begin
                        ov_next    = 1'b1;
                        kind_next  = KIND_COUNT;
                        value_next = val_reg;
                        pos_next   = len_reg;
                        // Unless a length word follows, the last emitted count is the last of the run
                        // or the one just below the limit.
                        last_next  = !fin_reg &&
                                     ((rem_reg == RUN_W'(1)) || (len_plus >= {1'b0, max_len}));
                    end
                    if (len_reg != LEN_MAX)
                    begin
                        len_next = len_plus[LEN_W-1:0];
                    end
                    rem_next = rem_reg - 1'b1;
                    if (rem_reg == RUN_W'(1))
                    begin
                        state_next = fin_reg ? S_LEN : S_IDLE;
                    end
                end
            end
            S_LEN:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    kind_next  = KIND_LENGTH;
                    value_next = (len_reg > LEN_W'(VALUE_MAX)) ? VALUE_MAX
                                                                : len_reg[COUNT_W-1:0];
                    pos_next   = len_reg;
                    last_next  = 1'b1;
                    len_next   = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rem_reg   <= '0;
            val_reg   <= '0;
            fin_reg   <= 1'b0;
            len_reg   <= '0;
            ov_reg    <= 1'b0;
            kind_reg  <= KIND_COUNT;
            value_reg <= '0;
            pos_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            val_reg   <= val_next;
            fin_reg   <= fin_next;
            len_reg   <= len_next;
            ov_reg    <= ov_next;
            kind_reg  <= kind_next;
            value_reg <= value_next;
            pos_reg   <= pos_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid = ov_reg;
    assign kind      = kind_reg;
    assign value     = value_reg;
    assign position  = pos_reg;
    assign last      = last_reg;

endmodule

// File: tb/cpdr_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpdr_tb_pkg: code tags of the compressed profile format
// Top bits that tell the kinds of codes apart. Shared by the stimulus
// and by the checker.
// ----------------------------------------------------------------------------
package cpdr_tb_pkg;

    localparam logic [1:0] TAG_RUN  = 2'b00;  // repeat the current count
    localparam logic [1:0] TAG_STEP = 2'b01;  // six-bit signed delta
    localparam logic       TAG_WIDE = 1'b1;   // first byte of a two-byte code

endpackage

// File: tb/cpdr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpdr_checker: decodes the accepted byte stream and checks every result word
// Follows the configuration port and the byte channel, decodes each accepted
// byte into the count and length words it must produce, and compares each
// word taken on the result channel, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module cpdr_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [cpdr_pkg::LEN_W-1:0]   cfg_wdata,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [cpdr_pkg::CODE_W-1:0]  code_byte,
    input  logic                         first_byte,
    input  logic                         final_byte,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic                         kind,
    input  logic [cpdr_pkg::COUNT_W-1:0] value,
    input  logic [cpdr_pkg::LEN_W-1:0]   position,
    input  logic                         last,
    output int                           errors,
    output int                           pending
);
    import cpdr_pkg::*;
    import cpdr_tb_pkg::*;

    typedef struct packed {
        logic               kind;
        logic [COUNT_W-1:0] value;
        logic [LEN_W-1:0]   position;
        logic               last;
    } decoded_word_t;

    decoded_word_t      expected_words[$];
    logic [COUNT_W-1:0] cur_count = '0;
    logic [LEN_W-1:0]   tally     = '0;
    logic [CODE_W-1:0]  held_byte = '0;
    pend_t              held_kind = PEND_NONE;
    logic [LEN_W-1:0]   limit     = LEN_MAX;
    int                 fail_count = 0;

    initial begin
        errors  = 0;
        pending = 0;
    end

    task automatic report(input string msg);
        $display("%0t ns decode check: %s", $time, msg);
        fail_count++;
    endtask

    task automatic clear_profile();
        cur_count = '0;
        tally     = '0;
        held_byte = '0;
        held_kind = PEND_NONE;
    endtask

    task automatic push_word(input logic k, input logic [COUNT_W-1:0] v,
                             input logic [LEN_W-1:0] p);
        decoded_word_t w;
        w.kind     = k;
        w.value    = v;
        w.position = p;
        w.last     = 1'b0;
        expected_words.push_back(w);
    endtask

    // Every count is tallied, but only positions below the limit come out.
    task automatic tally_count();
        if (tally < limit)
            push_word(KIND_COUNT, cur_count, tally);
        if (tally != LEN_MAX)
            tally = tally + 1'b1;
    endtask

    task automatic decode_byte(input logic [CODE_W-1:0] code, input logic first,
                               input logic fin);
        int                 base;
        logic [14:0]        wide;
        logic [COUNT_W-1:0] step;
        base = expected_words.size();
        if (first) begin
            clear_profile();
            if (code[7] == TAG_WIDE) begin
                held_kind = PEND_ABS;
                held_byte = code;
            end
            else begin
                cur_count = {8'h00, code};
                tally_count();
            end
        end
        else if (held_kind == PEND_ABS) begin
            cur_count = {1'b0, held_byte[6:0], code};
            held_kind = PEND_NONE;
            tally_count();
        end
        else if (held_kind == PEND_DELTA) begin
            // The wide delta wraps within 15 bits, so bit 15 always ends up clear.
            wide = {held_byte[6:0], code};
            cur_count = {1'b0, cur_count[14:0] + wide};
            held_kind = PEND_NONE;
            tally_count();
        end
        else if (code[7:6] == TAG_RUN) begin
            repeat (code[5:0]) tally_count();
        end
        else if (code[7:6] == TAG_STEP) begin
            step = {{10{code[5]}}, code[5:0]};
            cur_count = cur_count + step;
            tally_count();
        end
        else begin
            held_kind = PEND_DELTA;
            held_byte = code;
        end
        if (fin) begin
            push_word(KIND_LENGTH, (tally > {4'h0, VALUE_MAX}) ? VALUE_MAX : tally[15:0],
                      tally);
            clear_profile();
        end
        if (expected_words.size() > base)
            expected_words[expected_words.size() - 1].last = 1'b1;
    endtask

    task automatic check_word();
        decoded_word_t want;
        if (expected_words.size() == 0) begin
            report($sformatf("unexpected word kind=%0d value=%0d position=%0d last=%0d",
                             kind, value, position, last));
            return;
        end
        want = expected_words.pop_front();
        if (kind !== want.kind)
            report($sformatf("kind %0d, expected %0d", kind, want.kind));
        if (value !== want.value)
            report($sformatf("value %0d, expected %0d", value, want.value));
        if (position !== want.position)
            report($sformatf("position %0d, expected %0d", position, want.position));
        if (last !== want.last)
            report($sformatf("last %0d, expected %0d", last, want.last));
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            expected_words.delete();
            clear_profile();
            limit = LEN_MAX;
            pending <= 0;
        end
        else begin
            if (cfg_we)
                limit = cfg_wdata;
            // A word leaving now belongs to an earlier byte, so check before decoding.
            if (out_valid && out_ready)
                check_word();
            if (in_valid && in_ready)
                decode_byte(code_byte, first_byte, final_byte);
            pending <= expected_words.size();
            errors  <= fail_count;
        end
    end

endmodule

// File: tb/tb_count_profile_delta_run_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_count_profile_delta_run_decoder: stimulus and verdict for the decoder
// Feeds directed profiles, random profiles under several length limits and
// broken streams, with random gaps on both channels. The checker beside the
// block judges each word.
// ----------------------------------------------------------------------------
module tb_count_profile_delta_run_decoder;

    import cpdr_pkg::*;
    import cpdr_tb_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_WORDS   = 45;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               cfg_we     = 1'b0;
    logic [LEN_W-1:0]   cfg_wdata  = '0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic [CODE_W-1:0]  code_byte  = '0;
    logic               first_byte = 1'b0;
    logic               final_byte = 1'b0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic               kind;
    logic [COUNT_W-1:0] value;
    logic [LEN_W-1:0]   position;
    logic               last;

    int   errors;
    int   pending;
    int   words_sent  = 0;
    int   holds_asked = 0;
    int   holds_done  = 0;
    logic steady      = 1'b0;

    count_profile_delta_run_decoder uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .code_byte  (code_byte),
        .first_byte (first_byte),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .value      (value),
        .position   (position),
        .last       (last)
    );

    cpdr_checker decode_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .code_byte  (code_byte),
        .first_byte (first_byte),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .value      (value),
        .position   (position),
        .last       (last),
        .errors     (errors),
        .pending    (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #100_000_000;
        $display("** count_profile_delta_run_decoder: FAILED **");
        $finish;
    end

    // Result side: random stalls, a steady mode, and a long hold-off on request.
    initial
    begin
        forever begin
            @(posedge clk);
            if (holds_done != holds_asked) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else if (steady)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 35);
        end
    end

    function automatic logic [7:0] run_code(input int n);
        logic [31:0] bits;
        bits = n;
        return {TAG_RUN, bits[5:0]};
    endfunction

    function automatic logic [7:0] step_code(input int delta);
        logic [31:0] bits;
        bits = delta;
        return {TAG_STEP, bits[5:0]};
    endfunction

    function automatic logic [7:0] wide_head(input int high);
        logic [31:0] bits;
        bits = high;
        return {TAG_WIDE, bits[6:0]};
    endfunction

    task automatic send_word(input logic [7:0] code, input logic first, input logic fin);
        if (!steady && $urandom_range(99) < 35) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        code_byte  <= code;
        first_byte <= first;
        final_byte <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    // Stop offering and wait until every word due has come out.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_limit(input logic [LEN_W-1:0] lim);
        cfg_we    <= 1'b1;
        cfg_wdata <= lim;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_profile(input int n_codes);
        int   pick;
        logic fin;
        if ($urandom_range(1)) begin
            send_word(wide_head($urandom_range(127)), 1'b1, 1'b0);
            send_word(8'($urandom_range(255)), 1'b0, 1'b0);
        end
        else
            send_word({1'b0, 7'($urandom_range(127))}, 1'b1, 1'b0);
        for (int k = 1; k <= n_codes; k++) begin
            fin  = (k == n_codes);
            pick = $urandom_range(99);
            if (pick < 35) begin
                if ($urandom_range(9) < 7)
                    send_word(run_code($urandom_range(8)), 1'b0, fin);
                else
                    send_word(run_code($urandom_range(63)), 1'b0, fin);
            end
            else if (pick < 70)
                send_word(step_code($urandom_range(63)), 1'b0, fin);
            else begin
                send_word(wide_head($urandom_range(127)), 1'b0, 1'b0);
                send_word(8'($urandom_range(255)), 1'b0, fin);
            end
        end
    endtask

    // Loose bytes with stray start and end marks break codes at any point.
    task automatic send_noise(input int n);
        repeat (n)
            send_word(8'($urandom_range(255)), $urandom_range(9) == 0,
                      $urandom_range(9) == 0);
    endtask

    task automatic run_phase(input int target);
        int start;
        start = words_sent;
        while (words_sent - start < target) begin
            if ($urandom_range(99) < 80)
                send_profile($urandom_range(1, 12));
            else
                send_noise($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        logic [LEN_W-1:0] limits [6];
        limits = '{20'd0, 20'd3, 20'd17, 20'd60, LEN_MAX, 20'd1};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        set_limit(LEN_MAX);

        // Deltas at both extremes, a full run and a zero run.
        send_word(8'h00, 1'b1, 1'b0);
        send_word(run_code(63), 1'b0, 1'b0);
        send_word(step_code(31), 1'b0, 1'b0);
        send_word(step_code(-32), 1'b0, 1'b0);
        send_word(wide_head(127), 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(run_code(0), 1'b0, 1'b0);
        send_word(step_code(-1), 1'b0, 1'b1);
        // Largest two-byte start, then a wide code cut off by the end mark.
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(wide_head(0), 1'b0, 1'b0);
        send_word(8'h01, 1'b0, 1'b0);
        send_word(wide_head(64), 1'b0, 1'b1);
        // A one-byte profile, then bytes with no start mark; the first wraps to 65535.
        send_word(8'h7F, 1'b1, 1'b1);
        send_word(step_code(-1), 1'b0, 1'b0);
        send_word(run_code(3), 1'b0, 1'b0);
        send_word(run_code(0), 1'b0, 1'b1);
        // A two-byte start cut off at once, and one cut off by a new start.
        send_word(8'h80, 1'b1, 1'b1);
        send_word(8'h85, 1'b1, 1'b0);
        send_word(8'h10, 1'b1, 1'b0);
        send_word(run_code(2), 1'b0, 1'b1);
        send_word(8'h80, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(run_code(1), 1'b0, 1'b1);

        foreach (limits[i]) begin
            settle();
            set_limit(limits[i]);
            steady = (i == 3);
            // The result side holds off while bytes keep coming, so the block fills.
            if (i == 1)
                holds_asked++;
            run_phase(PHASE_WORDS);
        end

        settle();
        if (errors == 0)
            $display("** count_profile_delta_run_decoder: PASSED **");
        else
            $display("** count_profile_delta_run_decoder: FAILED **");
        $finish;
    end

endmodule
